// ----- rtl/pmawd_pkg.sv -----
// Package for the PowerPC memory access window decoder.
// Holds the request and response types, the opcode lists and the opcode lookup functions.
// Depends on nothing.
package pmawd_pkg;

	typedef struct packed {
		logic [31:0] instruction_word;
		logic [63:0] base_reg_value;
		logic [63:0] index_reg_value;
	} req_t;

	typedef struct packed {
		logic [63:0] effective_address;
		logic [7:0]  access_length;
	} rsp_t;

	// Length and the low address bits kept after alignment.
	typedef struct packed {
		logic [7:0] len;
		logic [6:0] keep;
	} xinfo_t;

	localparam logic [7:0] LEN_NONE  = 8'd0;
	localparam logic [7:0] LEN_BYTE  = 8'd1;
	localparam logic [7:0] LEN_HALF  = 8'd2;
	localparam logic [7:0] LEN_WORD  = 8'd4;
	localparam logic [7:0] LEN_DWORD = 8'd8;
	localparam logic [7:0] LEN_VEC   = 8'd16;
	localparam logic [7:0] LEN_LINE  = 8'd128;

	localparam logic [6:0] KEEP_ALL   = 7'h7f;
	localparam logic [6:0] KEEP_HALF  = 7'h7e;
	localparam logic [6:0] KEEP_WORD  = 7'h7c;
	localparam logic [6:0] KEEP_VEC   = 7'h70;
	localparam logic [6:0] KEEP_LINE  = 7'h00;

	localparam logic [5:0] PRI_XFORM  = 6'd31;
	localparam logic [5:0] PRI_LMW    = 6'd46;
	localparam logic [5:0] PRI_STMW   = 6'd47;
	localparam logic [5:0] PRI_DS_LD  = 6'd58;
	localparam logic [5:0] PRI_DS_STD = 6'd62;
	localparam logic [1:0] DS_SUB_LWA = 2'd2;
	localparam logic [5:0] LMW_WORDS  = 6'd32;

	localparam logic [7:0][5:0] PRI_LEN4 = {6'd32, 6'd33, 6'd36, 6'd37,
		6'd48, 6'd49, 6'd52, 6'd53};
	localparam logic [3:0][5:0] PRI_LEN1 = {6'd34, 6'd35, 6'd38, 6'd39};
	localparam logic [5:0][5:0] PRI_LEN2 = {6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45};
	localparam logic [3:0][5:0] PRI_LEN8 = {6'd50, 6'd51, 6'd54, 6'd55};

	localparam logic [5:0][9:0] XO_LEN1 = {10'd87, 10'd119, 10'd215, 10'd247,
		10'd7, 10'd135};
	localparam logic [7:0][9:0] XO_LEN2 = {10'd279, 10'd311, 10'd343, 10'd375,
		10'd407, 10'd439, 10'd790, 10'd918};
	localparam logic [14:0][9:0] XO_LEN4 = {10'd23, 10'd55, 10'd341, 10'd373,
		10'd151, 10'd183, 10'd534, 10'd662, 10'd535, 10'd567, 10'd663, 10'd695,
		10'd983, 10'd20, 10'd150};
	localparam logic [11:0][9:0] XO_LEN8 = {10'd21, 10'd53, 10'd149, 10'd181,
		10'd532, 10'd660, 10'd599, 10'd631, 10'd727, 10'd759, 10'd84, 10'd214};
	localparam logic [1:0][9:0] XO_ELEM_HALF = {10'd39, 10'd167};
	localparam logic [1:0][9:0] XO_ELEM_WORD = {10'd71, 10'd199};
	localparam logic [11:0][9:0] XO_VEC = {10'd103, 10'd359, 10'd231, 10'd487,
		10'd519, 10'd583, 10'd647, 10'd711, 10'd775, 10'd839, 10'd903, 10'd967};
	localparam logic [9:0] XO_DCBZ = 10'd1014;

	// Length of a fixed-length D-form access, or none.
	function automatic logic [7:0] pri_len(input logic [5:0] pri);
		logic [7:0] len;
		len = LEN_NONE;
		for (int i = 0; i < 8; i++) begin
			if (pri == PRI_LEN4[i]) len = LEN_WORD;
		end
		for (int i = 0; i < 4; i++) begin
			if (pri == PRI_LEN1[i]) len = LEN_BYTE;
			if (pri == PRI_LEN8[i]) len = LEN_DWORD;
		end
		for (int i = 0; i < 6; i++) begin
			if (pri == PRI_LEN2[i]) len = LEN_HALF;
		end
		return len;
	endfunction

	// Length and alignment of an indexed access, by extended opcode.
	function automatic xinfo_t xform_info(input logic [9:0] xo);
		xinfo_t info;
		info.len  = LEN_NONE;
		info.keep = KEEP_ALL;
		for (int i = 0; i < 6; i++) begin
			if (xo == XO_LEN1[i]) info.len = LEN_BYTE;
		end
		for (int i = 0; i < 8; i++) begin
			if (xo == XO_LEN2[i]) info.len = LEN_HALF;
		end
		for (int i = 0; i < 15; i++) begin
			if (xo == XO_LEN4[i]) info.len = LEN_WORD;
		end
		for (int i = 0; i < 12; i++) begin
			if (xo == XO_LEN8[i]) info.len = LEN_DWORD;
			if (xo == XO_VEC[i]) begin
				info.len  = LEN_VEC;
				info.keep = KEEP_VEC;
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (xo == XO_ELEM_HALF[i]) begin
				info.len  = LEN_HALF;
				info.keep = KEEP_HALF;
			end
			if (xo == XO_ELEM_WORD[i]) begin
				info.len  = LEN_WORD;
				info.keep = KEEP_WORD;
			end
		end
		if (xo == XO_DCBZ) begin
			info.len  = LEN_LINE;
			info.keep = KEEP_LINE;
		end
		return info;
	endfunction

endpackage

// ----- rtl/pmawd_decode.sv -----
// Combinational decode of one instruction into its memory window.
// Uses the types and opcode functions of pmawd_pkg.
module pmawd_decode (
	input  pmawd_pkg::req_t req,
	output pmawd_pkg::rsp_t rsp
);
	import pmawd_pkg::*;

	logic [5:0]  primary;
	logic [4:0]  ra;
	logic [4:0]  rt;
	logic [63:0] base;
	logic [63:0] disp_ext;
	logic [63:0] ds_ext;
	logic [63:0] addend;
	logic [63:0] sum;
	logic [7:0]  len;
	logic [6:0]  keep;
	xinfo_t      xinfo;

	assign primary  = req.instruction_word[31:26];
	assign rt       = req.instruction_word[25:21];
	assign ra       = req.instruction_word[20:16];
	assign base     = (ra == 5'd0) ? 64'd0 : req.base_reg_value;
	assign disp_ext = {{48{req.instruction_word[15]}}, req.instruction_word[15:0]};
	assign ds_ext   = {{48{req.instruction_word[15]}}, req.instruction_word[15:2], 2'b00};
	assign xinfo    = xform_info(req.instruction_word[10:1]);

	always_comb begin
		addend = disp_ext;
		keep   = KEEP_ALL;
		unique case (primary)
			PRI_LMW, PRI_STMW: begin
				len = {LMW_WORDS - {1'b0, rt}, 2'b00};
			end
			PRI_DS_LD: begin
				addend = ds_ext;
				len    = (req.instruction_word[1:0] == DS_SUB_LWA) ? LEN_WORD : LEN_DWORD;
			end
			PRI_DS_STD: begin
				addend = ds_ext;
				len    = LEN_DWORD;
			end
			PRI_XFORM: begin
				addend = req.index_reg_value;
				len    = xinfo.len;
				keep   = xinfo.keep;
			end
			default: begin
				len = pri_len(primary);
			end
		endcase
	end

	assign sum = base + addend;

	assign rsp.access_length     = len;
	assign rsp.effective_address = (len == LEN_NONE) ? 64'd0 : {sum[63:7], sum[6:0] & keep};

endmodule

// ----- rtl/ppc_mem_access_window_decode.sv -----
// A request is held in the input register, then its decoded window in the result register.
// Throughput: one request per cycle unless rsp_ready stalls; the input register advances
// when empty or when the result register advances, which it does when empty or drained.
// Decode and the single 64-bit address add sit between the two registers.
// Reset clears both valid flags; payload registers are not reset.
module ppc_mem_access_window_decode (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  pmawd_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output pmawd_pkg::rsp_t rsp
);
	import pmawd_pkg::*;

	logic valid_s1;
	logic valid_s2;
	req_t req_s1;
	rsp_t rsp_s2;
	rsp_t rsp_next;
	logic adv_s2;
	logic adv_s1;

	pmawd_decode u_decode (
		.req(req_s1),
		.rsp(rsp_next)
	);

	assign adv_s2    = !valid_s2 || rsp_ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign req_ready = adv_s1;
	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= req_valid;
			if (adv_s2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && req_valid) req_s1 <= req;
		if (adv_s2 && valid_s1) rsp_s2 <= rsp_next;
	end

endmodule

// ----- rtl/pmawd_checker.sv -----
// Port-level assertions for the memory access window decoder, bound to the top level.
// Uses the types of pmawd_pkg.
module pmawd_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            req_valid,
	input logic            req_ready,
	input logic            rsp_valid,
	input logic            rsp_ready,
	input pmawd_pkg::rsp_t rsp
);
	import pmawd_pkg::*;

	// A stalled response must hold.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// A response that starts a new burst comes from a request accepted through the input register.
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
		else $error("response without a matching request");

	// An unrecognized instruction reports address zero.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.access_length == LEN_NONE |-> rsp.effective_address == 64'd0)
		else $error("nonzero address for unrecognized instruction");

	// Lengths never exceed one cache line.
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.access_length <= LEN_LINE)
		else $error("access length out of range");

endmodule

bind ppc_mem_access_window_decode pmawd_checker u_pmawd_checker (.*);

// ----- test/ppc_mem_access_window_decode_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the PowerPC memory access window decoder.
// Checks the effective address and access length of every response against its own decoder.
// Depends on pmawd_pkg and ppc_mem_access_window_decode.
module ppc_mem_access_window_decode_tb;
	import pmawd_pkg::*;

	localparam int STUCK_LIMIT  = 1000;
	localparam int HOLD_CYCLES  = 60;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_REPORTS  = 100;
	localparam int REG_COUNT    = 32;

	localparam int D_BYTE_OPS [4]  = '{34, 35, 38, 39};
	localparam int D_HALF_OPS [6]  = '{40, 41, 42, 43, 44, 45};
	localparam int D_WORD_OPS [8]  = '{32, 33, 36, 37, 48, 49, 52, 53};
	localparam int D_DWORD_OPS [4] = '{50, 51, 54, 55};

	localparam int X_BYTE_XO [6]      = '{87, 119, 215, 247, 7, 135};
	localparam int X_HALF_XO [8]      = '{279, 311, 343, 375, 407, 439, 790, 918};
	localparam int X_WORD_XO [15]     = '{23, 55, 341, 373, 151, 183, 534, 662, 535, 567,
		663, 695, 983, 20, 150};
	localparam int X_DWORD_XO [12]    = '{21, 53, 149, 181, 532, 660, 599, 631, 727, 759,
		84, 214};
	localparam int X_ELEM_HALF_XO [2] = '{39, 167};
	localparam int X_ELEM_WORD_XO [2] = '{71, 199};
	localparam int X_VEC_XO [12]      = '{103, 359, 231, 487, 519, 583, 647, 711, 775, 839,
		903, 967};

	localparam int XO_UNLISTED_LOW  = 0;
	localparam int XO_UNLISTED_HIGH = 1023;
	localparam int PRI_NONE_LOW     = 0;
	localparam int PRI_NONE_HIGH    = 63;

	localparam logic [1:0] DS_SUB_LD   = 2'd0;
	localparam logic [1:0] DS_SUB_LDU  = 2'd1;
	localparam logic [1:0] DS_SUB_RSVD = 2'd3;

	localparam logic [63:0] ALIGN_NONE = '1;
	localparam logic [63:0] ALIGN_HALF = ~64'd1;
	localparam logic [63:0] ALIGN_WORD = ~64'd3;
	localparam logic [63:0] ALIGN_VEC  = ~64'd15;
	localparam logic [63:0] ALIGN_LINE = ~64'd127;

	typedef struct {
		logic [31:0] insn;
		rsp_t        window;
	} pending_window_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;

	pending_window_t pending_windows[$];
	int mismatches = 0;
	int requests_sent = 0;
	int accesses_seen = 0;
	int non_accesses_seen = 0;
	int stuck_cycles = 0;
	int hold_left = 0;
	int stall_left = 0;
	bit long_hold = 1'b0;
	bit gaps_on = 1'b1;

	ppc_mem_access_window_decode dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic rsp_t decode_window(input req_t r);
		rsp_t        w;
		logic [31:0] insn;
		logic [5:0]  pri;
		logic [4:0]  rt;
		logic [4:0]  ra;
		int          xo;
		logic [63:0] base;
		logic [63:0] d_ea;
		logic [63:0] ds_ea;
		logic [63:0] align;
		logic [7:0]  len;
		insn  = r.instruction_word;
		pri   = insn[31:26];
		rt    = insn[25:21];
		ra    = insn[20:16];
		xo    = int'(insn[10:1]);
		base  = (ra == 5'd0) ? 64'd0 : r.base_reg_value;
		d_ea  = base + {{48{insn[15]}}, insn[15:0]};
		ds_ea = base + {{48{insn[15]}}, insn[15:2], 2'b00};
		len   = LEN_NONE;
		w     = '0;
		foreach (D_BYTE_OPS[i]) if (int'(pri) == D_BYTE_OPS[i]) len = LEN_BYTE;
		foreach (D_HALF_OPS[i]) if (int'(pri) == D_HALF_OPS[i]) len = LEN_HALF;
		foreach (D_WORD_OPS[i]) if (int'(pri) == D_WORD_OPS[i]) len = LEN_WORD;
		foreach (D_DWORD_OPS[i]) if (int'(pri) == D_DWORD_OPS[i]) len = LEN_DWORD;
		if (len != LEN_NONE) begin
			w.effective_address = d_ea;
		end else if (pri == PRI_LMW || pri == PRI_STMW) begin
			w.effective_address = d_ea;
			len = 8'((REG_COUNT - int'(rt)) * 4);
		end else if (pri == PRI_DS_LD) begin
			w.effective_address = ds_ea;
			len = (insn[1:0] == DS_SUB_LWA) ? LEN_WORD : LEN_DWORD;
		end else if (pri == PRI_DS_STD) begin
			w.effective_address = ds_ea;
			len = LEN_DWORD;
		end else if (pri == PRI_XFORM) begin
			align = ALIGN_NONE;
			foreach (X_BYTE_XO[i]) if (xo == X_BYTE_XO[i]) len = LEN_BYTE;
			foreach (X_HALF_XO[i]) if (xo == X_HALF_XO[i]) len = LEN_HALF;
			foreach (X_WORD_XO[i]) if (xo == X_WORD_XO[i]) len = LEN_WORD;
			foreach (X_DWORD_XO[i]) if (xo == X_DWORD_XO[i]) len = LEN_DWORD;
			foreach (X_ELEM_HALF_XO[i]) begin
				if (xo == X_ELEM_HALF_XO[i]) begin
					len = LEN_HALF;
					align = ALIGN_HALF;
				end
			end
			foreach (X_ELEM_WORD_XO[i]) begin
				if (xo == X_ELEM_WORD_XO[i]) begin
					len = LEN_WORD;
					align = ALIGN_WORD;
				end
			end
			foreach (X_VEC_XO[i]) begin
				if (xo == X_VEC_XO[i]) begin
					len = LEN_VEC;
					align = ALIGN_VEC;
				end
			end
			if (xo == int'(XO_DCBZ)) begin
				len = LEN_LINE;
				align = ALIGN_LINE;
			end
			if (len != LEN_NONE) begin
				w.effective_address = (base + r.index_reg_value) & align;
			end
		end
		w.access_length = len;
		return w;
	endfunction

	function automatic logic [31:0] d_insn(input int pri, input int rt, input int ra,
		input logic [15:0] low);
		return {6'(pri), 5'(rt), 5'(ra), low};
	endfunction

	function automatic logic [31:0] x_insn(input int rt, input int ra, input int rb,
		input int xo);
		return {PRI_XFORM, 5'(rt), 5'(ra), 5'(rb), 10'(xo), 1'b0};
	endfunction

	function automatic logic [63:0] random_reg();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {1'b1, 63'd0};
			3: return {32'hffffffff, $urandom} | 64'h7f;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [31:0] random_insn();
		logic [31:0] w;
		int          xo;
		w = $urandom;
		case ($urandom_range(0, 11))
			0: w[31:26] = 6'(D_BYTE_OPS[$urandom_range(0, 3)]);
			1: w[31:26] = 6'(D_HALF_OPS[$urandom_range(0, 5)]);
			2: w[31:26] = 6'(D_WORD_OPS[$urandom_range(0, 7)]);
			3: w[31:26] = 6'(D_DWORD_OPS[$urandom_range(0, 3)]);
			4: w[31:26] = ($urandom_range(0, 1) == 0) ? PRI_LMW : PRI_STMW;
			5: w[31:26] = PRI_DS_LD;
			6: w[31:26] = PRI_DS_STD;
			7, 8, 9: begin
				case ($urandom_range(0, 7))
					0: xo = X_BYTE_XO[$urandom_range(0, 5)];
					1: xo = X_HALF_XO[$urandom_range(0, 7)];
					2: xo = X_WORD_XO[$urandom_range(0, 14)];
					3: xo = X_DWORD_XO[$urandom_range(0, 11)];
					4: xo = X_ELEM_HALF_XO[$urandom_range(0, 1)];
					5: xo = X_ELEM_WORD_XO[$urandom_range(0, 1)];
					6: xo = X_VEC_XO[$urandom_range(0, 11)];
					default: xo = int'(XO_DCBZ);
				endcase
				w[31:26] = PRI_XFORM;
				w[10:1] = 10'(xo);
			end
			10: w[31:26] = PRI_XFORM;
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0) w[20:16] = 5'd0;
		return w;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] insn,
		input logic [63:0] got, input logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_REPORTS) begin
			$display("%0t: %s mismatch for instruction %08h: got %h, expected %h",
				$realtime, what, insn, got, want);
		end
	endtask

	task automatic send_request(input logic [31:0] insn, input logic [63:0] base,
		input logic [63:0] index);
		req_t            r;
		pending_window_t p;
		r.instruction_word = insn;
		r.base_reg_value   = base;
		r.index_reg_value  = index;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		p.insn = insn;
		p.window = decode_window(r);
		pending_windows.insert(pending_windows.size(), p);
		requests_sent++;
	endtask

	always @(posedge clk) begin : check_responses
		pending_window_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_windows.size() == 0) begin
					report_mismatch("unexpected response", '0, rsp.effective_address, '0);
				end else begin
					want = pending_windows.pop_front();
					if (rsp.effective_address !== want.window.effective_address) begin
						report_mismatch("effective_address", want.insn,
							rsp.effective_address, want.window.effective_address);
					end
					if (rsp.access_length !== want.window.access_length) begin
						report_mismatch("access_length", want.insn,
							64'(rsp.access_length), 64'(want.window.access_length));
					end
					if (want.window.access_length == LEN_NONE) non_accesses_seen++;
					else accesses_seen++;
				end
			end
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles == STUCK_LIMIT) begin
					$display("no request moved for %0d cycles", STUCK_LIMIT);
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (long_hold) begin
			hold_left = HOLD_CYCLES;
			long_hold = 1'b0;
		end
		if (hold_left != 0) begin
			rsp_ready <= 1'b0;
			hold_left--;
		end else if (stall_left != 0) begin
			rsp_ready <= 1'b0;
			stall_left--;
		end else if (gaps_on && arst_n && $urandom_range(0, 4) == 0) begin
			rsp_ready <= 1'b0;
			stall_left = $urandom_range(0, 4);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	task automatic test_directed_cases();
		send_request(d_insn(D_BYTE_OPS[0], 3, 1, 16'h7fff), 64'h1000, '0);
		send_request(d_insn(D_HALF_OPS[0], 4, 2, 16'h8000), 64'h10, '1);
		send_request(d_insn(D_WORD_OPS[0], 5, 0, 16'h0010), '1, '1);
		send_request(d_insn(D_DWORD_OPS[3], 6, 3, 16'h0001), '1, '0);
		send_request(d_insn(PRI_LMW, 0, 4, 16'hfff0), 64'h2000, '0);
		send_request(d_insn(PRI_STMW, 31, 5, 16'h0004), 64'h2000, '0);
		send_request(d_insn(PRI_DS_LD, 7, 6, {14'h1fff, DS_SUB_LD}), 64'h8000, '0);
		send_request(d_insn(PRI_DS_LD, 7, 6, {14'h2000, DS_SUB_LDU}), 64'h8000, '0);
		send_request(d_insn(PRI_DS_LD, 7, 6, {14'h0005, DS_SUB_LWA}), 64'h8000, '0);
		send_request(d_insn(PRI_DS_LD, 7, 0, {14'h3fff, DS_SUB_RSVD}), '1, '0);
		send_request(d_insn(PRI_DS_STD, 8, 7, 16'hfffd), 64'h4, '0);
		send_request(x_insn(1, 2, 3, X_BYTE_XO[0]), 64'h1001, 64'h2);
		send_request(x_insn(1, 2, 3, X_HALF_XO[6]), 64'h1001, 64'h3);
		send_request(x_insn(1, 2, 3, X_WORD_XO[13]), '1, 64'h5);
		send_request(x_insn(1, 2, 3, X_DWORD_XO[0]), '1, 64'h1);
		send_request(x_insn(1, 2, 3, X_ELEM_HALF_XO[0]), 64'h3001, 64'h2);
		send_request(x_insn(1, 2, 3, X_ELEM_WORD_XO[1]), 64'h3003, 64'h2);
		send_request(x_insn(1, 2, 3, X_VEC_XO[0]), 64'h300f, 64'h1);
		send_request(x_insn(1, 0, 3, XO_DCBZ), '1, 64'hffff_ffff_ffff_ffff);
		send_request(x_insn(31, 31, 31, XO_UNLISTED_LOW), '1, '1);
		send_request(x_insn(31, 31, 31, XO_UNLISTED_HIGH), '1, '1);
		send_request(d_insn(PRI_NONE_LOW, 0, 0, 16'h0000), '1, '1);
		send_request(d_insn(PRI_NONE_HIGH, 31, 31, 16'hffff), '1, '1);
		send_request(x_insn(9, 9, 9, X_DWORD_XO[1]), {1'b1, 63'd0}, {1'b1, 63'd0});
	endtask

	task automatic test_random_stream();
		repeat (1200) send_request(random_insn(), random_reg(), random_reg());
	endtask

	task automatic test_full_pipe_stall();
		gaps_on = 1'b0;
		long_hold = 1'b1;
		repeat (40) send_request(random_insn(), random_reg(), random_reg());
		gaps_on = 1'b1;
	endtask

	task automatic test_idle_free_stream();
		gaps_on = 1'b0;
		repeat (40) send_request(random_insn(), random_reg(), random_reg());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_random_stream();
		test_full_pipe_stall();
		test_idle_free_stream();
		req_valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Decoded %0d requests: %0d memory accesses and %0d non-accesses,",
			requests_sent, accesses_seen, non_accesses_seen);
		$display("with random idling, a long output hold-off and a gap-free final stream.");
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
